[hdl/obhb_pkg.sv]
// package for the one-sided horizontal blur unit
// shared constants, register indexes, fsm states and the result word type
// no dependencies
`default_nettype none

package obhb_pkg;

  localparam int CHAN_W       = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int BLUR_CFG_W   = 6;

  localparam int DEF_MAX_BLUR    = 63;
  localparam int DEF_WIDTH_LIMIT = 4096;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [BLUR_CFG_W-1:0] BLUR_RST   = 6'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BLUR   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_OWN_RD,
    ST_OWN_W,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_START,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              last_of_run;
    logic              end_of_image;
  } res_word_t;

endpackage

`default_nettype wire

[hdl/obhb_if.sv]
// stream interfaces of the blur unit: pixel in, result out, register write
// depends on obhb_pkg
`default_nettype none

interface obhb_pix_if;
  logic                          valid;
  logic                          ready;
  logic [obhb_pkg::CHAN_W-1:0]   red_in;
  logic [obhb_pkg::CHAN_W-1:0]   green_in;
  logic [obhb_pkg::CHAN_W-1:0]   blue_in;
  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface obhb_res_if;
  logic                          valid;
  logic                          ready;
  logic [obhb_pkg::CHAN_W-1:0]   red_out;
  logic [obhb_pkg::CHAN_W-1:0]   green_out;
  logic [obhb_pkg::CHAN_W-1:0]   blue_out;
  logic                          last_of_run;
  logic                          end_of_image;
  modport source (output valid, red_out, green_out, blue_out, last_of_run, end_of_image,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, last_of_run, end_of_image,
                  output ready);
endinterface

interface obhb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [obhb_pkg::CFG_IDX_W-1:0]    index;
  logic [obhb_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/one_sided_horizontal_blur_unit.sv]
// top level of the one-sided horizontal blur unit: pixel queue, window sums, control
// depends on obhb_pkg, obhb_if, obhb_lane, obhb_merge
//
// Each channel of a pixel becomes floor((n*own + S)/(2n)), S the sum of the next n pixels
// of its row, n = min(blur setting, pixels left in the row). Pixels wait in a queue memory
// of MAX_BLUR+1 entries until their window is complete; the row's last pixel flushes the
// rest. A pixel is taken only while no result is being worked on: a pixel passes a check,
// and each result it gives an own-pixel read and the bit-serial divider (NW = numerator
// width, 15 for MAX_BLUR 63) that the three channel lanes run in parallel, and it may then
// wait on the output. After the blur setting is lowered mid-row, each surplus result also
// makes a sum pass over its window pixels in the queue memory.
// The output register lets a new pixel in while the last result waits.
`default_nettype none

module one_sided_horizontal_blur_unit #(
  parameter int MAX_BLUR    = obhb_pkg::DEF_MAX_BLUR,
  parameter int WIDTH_LIMIT = obhb_pkg::DEF_WIDTH_LIMIT
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  obhb_pix_if.sink     pix_i,
  obhb_cfg_if.sink     cfg_i,
  obhb_res_if.source   res_o
);

  localparam int CH   = obhb_pkg::CHAN_W;
  localparam int QD   = MAX_BLUR + 1;
  localparam int PW   = (QD > 1) ? $clog2(QD) : 1;
  localparam int BW   = $clog2(MAX_BLUR + 1);
  localparam int NCW  = $clog2(MAX_BLUR + 2);
  localparam int SUMW = $clog2((MAX_BLUR + 1) * 255 + 1);
  localparam int NW   = $clog2(2 * MAX_BLUR * 255 + 1);
  localparam int CW   = $clog2(WIDTH_LIMIT);
  localparam int WW   = $clog2(WIDTH_LIMIT + 1);
  localparam int EW   = (WW > obhb_pkg::CFG_DATA_W) ? WW : obhb_pkg::CFG_DATA_W;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QD - 1)) ? '0 : p + 1'b1;
  endfunction

  obhb_pkg::state_e state_q, state_d;

  logic [obhb_pkg::CFG_DATA_W-1:0] width_q, height_q;
  logic [obhb_pkg::BLUR_CFG_W-1:0] blur_q;

  logic [2:0][CH-1:0]   mem [QD];
  logic [2:0][CH-1:0]   rdata_q;
  logic [PW-1:0]        raddr;

  logic [PW-1:0]        head_q, tail_q, sptr_q;
  logic [NCW-1:0]       cnt_q;
  logic [SUMW-1:0]      wsum_q [3];
  logic [SUMW-1:0]      s_q    [3];
  logic [2:0][CH-1:0]   own_q;
  logic [BW-1:0]        n_q, scnt_q;
  logic [CW-1:0]        col_q, row_q;
  logic                 row_end_q, eoi_q;

  logic [EW-1:0]        w_eff, h_eff;
  logic [BW-1:0]        blur_eff;
  logic [2:0][CH-1:0]   px;
  logic                 accept, row_end, img_end;
  logic                 normal, sweep, more, emit_rdy;
  logic [NCW-1:0]       cnt_m1;
  logic                 start, load;
  logic [2:0]           lane_done;
  logic [2:0][CH-1:0]   quo;
  obhb_pkg::res_word_t  word;

  always_comb begin
    if (width_q == '0) begin
      w_eff = EW'(1);
    end else if (EW'(width_q) > EW'(WIDTH_LIMIT)) begin
      w_eff = EW'(WIDTH_LIMIT);
    end else begin
      w_eff = EW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = EW'(1);
    end else if (EW'(height_q) > EW'(WIDTH_LIMIT)) begin
      h_eff = EW'(WIDTH_LIMIT);
    end else begin
      h_eff = EW'(height_q);
    end
    if (blur_q > obhb_pkg::BLUR_CFG_W'(MAX_BLUR)) begin
      blur_eff = BW'(MAX_BLUR);
    end else begin
      blur_eff = blur_q[BW-1:0];
    end
  end

  assign px      = {pix_i.red_in, pix_i.green_in, pix_i.blue_in};
  assign accept  = pix_i.valid && pix_i.ready;
  assign row_end = (EW'(col_q) + EW'(1)) >= w_eff;
  assign img_end = (EW'(row_q) + EW'(1)) >= h_eff;
  assign normal  = cnt_q > NCW'(blur_eff);
  assign sweep   = normal && (blur_eff != '0) && (cnt_q != (NCW'(blur_eff) + 1'b1));
  assign cnt_m1  = cnt_q - 1'b1;
  assign more    = (cnt_m1 > NCW'(blur_eff)) || (row_end_q && (cnt_m1 != '0));
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= obhb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pix_i.ready = 1'b0;
    start       = 1'b0;
    load        = 1'b0;
    raddr       = sptr_q;
    case (state_q)
      obhb_pkg::ST_IDLE: begin
        pix_i.ready = 1'b1;
        if (pix_i.valid) begin
          state_d = obhb_pkg::ST_CHECK;
        end
      end
      obhb_pkg::ST_CHECK: begin
        if (normal || (row_end_q && (cnt_q != '0))) begin
          state_d = obhb_pkg::ST_OWN_RD;
        end else begin
          state_d = obhb_pkg::ST_IDLE;
        end
      end
      obhb_pkg::ST_OWN_RD: begin
        raddr   = head_q;
        state_d = obhb_pkg::ST_OWN_W;
      end
      obhb_pkg::ST_OWN_W: begin
        state_d = sweep ? obhb_pkg::ST_SUM_RD : obhb_pkg::ST_START;
      end
      obhb_pkg::ST_SUM_RD: begin
        state_d = obhb_pkg::ST_SUM_ACC;
      end
      obhb_pkg::ST_SUM_ACC: begin
        state_d = (scnt_q == BW'(1)) ? obhb_pkg::ST_START : obhb_pkg::ST_SUM_RD;
      end
      obhb_pkg::ST_START: begin
        start = 1'b1;
        if (&lane_done) begin
          state_d = obhb_pkg::ST_EMIT;
        end
      end
      obhb_pkg::ST_EMIT: begin
        if (emit_rdy) begin
          load    = 1'b1;
          state_d = obhb_pkg::ST_CHECK;
        end
      end
      default: begin
        state_d = obhb_pkg::ST_IDLE;
      end
    endcase
  end

  // lanes start on the first cycle of ST_START only
  logic start_seen_q;
  logic start_p;
  assign start_p = start && !start_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_seen_q <= 1'b0;
    end else begin
      start_seen_q <= start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= obhb_pkg::WIDTH_RST;
      height_q <= obhb_pkg::HEIGHT_RST;
      blur_q   <= obhb_pkg::BLUR_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (obhb_pkg::cfg_idx_e'(cfg_i.index))
        obhb_pkg::REG_WIDTH:  width_q  <= cfg_i.data;
        obhb_pkg::REG_HEIGHT: height_q <= cfg_i.data;
        obhb_pkg::REG_BLUR:   blur_q   <= cfg_i.data[obhb_pkg::BLUR_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[tail_q] <= px;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      row_end_q <= 1'b0;
      eoi_q     <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        wsum_q[c] <= '0;
      end
    end else begin
      if (accept) begin
        tail_q    <= ptr_inc(tail_q);
        cnt_q     <= cnt_q + 1'b1;
        row_end_q <= row_end;
        eoi_q     <= row_end && img_end;
        for (int c = 0; c < 3; c++) begin
          wsum_q[c] <= wsum_q[c] + SUMW'(px[c]);
        end
        if (row_end) begin
          col_q <= '0;
          row_q <= img_end ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end else if (load) begin
        head_q <= ptr_inc(head_q);
        cnt_q  <= cnt_m1;
        for (int c = 0; c < 3; c++) begin
          wsum_q[c] <= wsum_q[c] - SUMW'(own_q[c]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      obhb_pkg::ST_OWN_W: begin
        own_q  <= rdata_q;
        sptr_q <= ptr_inc(head_q);
        scnt_q <= blur_eff;
        n_q    <= normal ? blur_eff : cnt_m1[BW-1:0];
        for (int c = 0; c < 3; c++) begin
          s_q[c] <= sweep ? '0 : wsum_q[c] - SUMW'(rdata_q[c]);
        end
      end
      obhb_pkg::ST_SUM_ACC: begin
        sptr_q <= ptr_inc(sptr_q);
        scnt_q <= scnt_q - 1'b1;
        for (int c = 0; c < 3; c++) begin
          s_q[c] <= s_q[c] + SUMW'(rdata_q[c]);
        end
      end
      default: ;
    endcase
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    obhb_lane #(
      .BW   (BW),
      .SUMW (SUMW),
      .NW   (NW)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (start_p),
      .n_i     (n_q),
      .own_i   (own_q[c]),
      .s_i     (s_q[c]),
      .done_o  (lane_done[c]),
      .quo_o   (quo[c])
    );
  end

  always_comb begin
    word.red_out      = quo[2];
    word.green_out    = quo[1];
    word.blue_out     = quo[0];
    word.last_of_run  = !more;
    word.end_of_image = !more && eoi_q;
  end

  obhb_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .word_i     (word),
    .load_rdy_o (emit_rdy),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

[hdl/obhb_lane.sv]
// one channel lane: divides n*own + s by 2n (own by 2 if n is 0), one quotient bit a cycle
// depends on obhb_pkg
`default_nettype none

module obhb_lane #(
  parameter int BW   = 6,
  parameter int SUMW = 14,
  parameter int NW   = 15
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [BW-1:0]                 n_i,
  input  wire logic [obhb_pkg::CHAN_W-1:0]   own_i,
  input  wire logic [SUMW-1:0]               s_i,
  output logic                               done_o,
  output logic [obhb_pkg::CHAN_W-1:0]        quo_o
);

  localparam int DW = BW + 1;
  localparam int KW = $clog2(NW + 1);

  logic [NW-1:0] num_q;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem_q;
  logic [NW-1:0] quo_q;
  logic [KW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [DW:0]   rem2;
  logic          ge;
  logic [DW:0]   rem_n;

  assign rem2  = {rem_q, num_q[NW-1]};
  assign ge    = rem2 >= {1'b0, den_q};
  assign rem_n = ge ? (rem2 - {1'b0, den_q}) : rem2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= KW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == KW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= '0;
      if (n_i == '0) begin
        num_q <= NW'(own_i);
        den_q <= DW'(2);
      end else begin
        num_q <= NW'(NW'(n_i) * NW'(own_i)) + NW'(s_i);
        den_q <= {n_i, 1'b0};
      end
    end else if (busy_q) begin
      rem_q <= rem_n[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
      num_q <= {num_q[NW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q[obhb_pkg::CHAN_W-1:0];

endmodule

`default_nettype wire

[hdl/obhb_merge.sv]
// merging stage: joins the three lane quotients and flags into one result word
// and holds it in the output register; depends on obhb_pkg, obhb_if
`default_nettype none

module obhb_merge (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire obhb_pkg::res_word_t  word_i,
  output logic                      load_rdy_o,
  obhb_res_if.source                res_o
);

  obhb_pkg::res_word_t word_q;
  logic                valid_q;

  assign load_rdy_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.red_out      = word_q.red_out;
  assign res_o.green_out    = word_q.green_out;
  assign res_o.blue_out     = word_q.blue_out;
  assign res_o.last_of_run  = word_q.last_of_run;
  assign res_o.end_of_image = word_q.end_of_image;

endmodule

`default_nettype wire

[dv/obhb_blur_checker.sv]
// checker for the one-sided horizontal blur unit: watches the register, pixel and result
// channels, predicts the blurred words and compares them field by field
// depends on obhb_pkg and obhb_if
`default_nettype none

module obhb_blur_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  obhb_pix_if       pix,
  obhb_cfg_if       cfg,
  obhb_res_if       res,
  output int        errors_o,
  output int        waiting_o
);

  localparam int MAX_BLUR    = obhb_pkg::DEF_MAX_BLUR;
  localparam int WIDTH_LIMIT = obhb_pkg::DEF_WIDTH_LIMIT;

  logic [obhb_pkg::CFG_DATA_W-1:0] width_reg;
  logic [obhb_pkg::CFG_DATA_W-1:0] height_reg;
  logic [obhb_pkg::BLUR_CFG_W-1:0] blur_reg;

  logic [23:0]          row_pixels[$];
  int unsigned          sum_red, sum_green, sum_blue;
  int unsigned          col_cnt, row_cnt;
  obhb_pkg::res_word_t  blurred_q[$];

  function automatic int unsigned clamp_size(logic [obhb_pkg::CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > WIDTH_LIMIT) return WIDTH_LIMIT;
    return v;
  endfunction

  function automatic logic [7:0] blur_chan(int unsigned own, int unsigned n, int unsigned s);
    if (n == 0) return 8'(own >> 1);
    return 8'((n * own + s) / (2 * n));
  endfunction

  function automatic obhb_pkg::res_word_t blur_word(logic [23:0] own, int unsigned n,
                                                    int unsigned sr, int unsigned sg,
                                                    int unsigned sb);
    obhb_pkg::res_word_t w;
    w.red_out      = blur_chan(own[23:16], n, sr);
    w.green_out    = blur_chan(own[15:8], n, sg);
    w.blue_out     = blur_chan(own[7:0], n, sb);
    w.last_of_run  = 1'b0;
    w.end_of_image = 1'b0;
    return w;
  endfunction

  function automatic void drop_oldest();
    logic [23:0] p;
    p = row_pixels.pop_front();
    sum_red   -= p[23:16];
    sum_green -= p[15:8];
    sum_blue  -= p[7:0];
  endfunction

  task automatic blur_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned         w, h, n, sr, sg, sb;
    bit                  row_end;
    obhb_pkg::res_word_t run[$];
    logic [23:0]         own;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    n = (blur_reg > MAX_BLUR) ? MAX_BLUR : blur_reg;
    row_end = (col_cnt + 1) >= w;
    row_pixels.push_back({r, g, b});
    sum_red += r;
    sum_green += g;
    sum_blue += b;
    while (row_pixels.size() > n) begin
      own = row_pixels[0];
      sr = 0; sg = 0; sb = 0;
      for (int i = 1; i <= n; i++) begin
        sr += row_pixels[i][23:16];
        sg += row_pixels[i][15:8];
        sb += row_pixels[i][7:0];
      end
      run.push_back(blur_word(own, n, sr, sg, sb));
      drop_oldest();
    end
    if (row_end) begin
      while (row_pixels.size() > 0) begin
        own = row_pixels[0];
        run.push_back(blur_word(own, row_pixels.size() - 1, sum_red - own[23:16],
                                sum_green - own[15:8], sum_blue - own[7:0]));
        drop_oldest();
      end
      col_cnt = 0;
      if (row_cnt + 1 >= h) begin
        if (run.size() > 0) run[run.size()-1].end_of_image = 1'b1;
        row_cnt = 0;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end
    if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) blurred_q.push_back(run[i]);
  endtask

  task automatic check_word();
    obhb_pkg::res_word_t want;
    if (blurred_q.size() == 0) begin
      $error("result word with none expected: r=%0d g=%0d b=%0d", res.red_out,
             res.green_out, res.blue_out);
      errors_o++;
      return;
    end
    want = blurred_q.pop_front();
    if (res.red_out !== want.red_out) begin
      $error("red_out expected %0d actual %0d", want.red_out, res.red_out);
      errors_o++;
    end
    if (res.green_out !== want.green_out) begin
      $error("green_out expected %0d actual %0d", want.green_out, res.green_out);
      errors_o++;
    end
    if (res.blue_out !== want.blue_out) begin
      $error("blue_out expected %0d actual %0d", want.blue_out, res.blue_out);
      errors_o++;
    end
    if (res.last_of_run !== want.last_of_run) begin
      $error("last_of_run expected %0d actual %0d", want.last_of_run, res.last_of_run);
      errors_o++;
    end
    if (res.end_of_image !== want.end_of_image) begin
      $error("end_of_image expected %0d actual %0d", want.end_of_image, res.end_of_image);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  <= obhb_pkg::WIDTH_RST;
      height_reg <= obhb_pkg::HEIGHT_RST;
      blur_reg   <= obhb_pkg::BLUR_RST;
      row_pixels.delete();
      blurred_q.delete();
      sum_red   = 0;
      sum_green = 0;
      sum_blue  = 0;
      col_cnt   = 0;
      row_cnt   = 0;
      errors_o  = 0;
      waiting_o = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (obhb_pkg::cfg_idx_e'(cfg.index))
          obhb_pkg::REG_WIDTH:  width_reg  <= cfg.data;
          obhb_pkg::REG_HEIGHT: height_reg <= cfg.data;
          obhb_pkg::REG_BLUR:   blur_reg   <= cfg.data[obhb_pkg::BLUR_CFG_W-1:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) blur_pixel(pix.red_in, pix.green_in, pix.blue_in);
      if (res.valid && res.ready) check_word();
      waiting_o = blurred_q.size();
    end
  end

endmodule

`default_nettype wire

[dv/testbench.sv]
// top of the blur unit testbench: clock, reset, pixel and register stimulus, result stalls
// depends on obhb_pkg, obhb_if, obhb_blur_checker and the blur unit
`default_nettype none

module testbench;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, waiting, cycles;
  int   hold_kicks = 0;
  int   kicks_seen = 0;
  int   hold_left = 0;
  bit   gaps_off;
  int   sent;

  obhb_pix_if pix();
  obhb_cfg_if cfg();
  obhb_res_if res();

  one_sided_horizontal_blur_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  obhb_blur_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix       (pix),
    .cfg       (cfg),
    .res       (res),
    .errors_o  (errors),
    .waiting_o (waiting)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side stalls
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (kicks_seen != hold_kicks) begin
        kicks_seen = hold_kicks;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (gaps_off || $urandom_range(0, 99) < 65) begin
        res.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 90) begin
        res.ready <= 1'b0;
      end else begin
        hold_left = $urandom_range(15, 60);
        res.ready <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (gaps_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_chan();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 8'd0;
    if (r < 24) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid    <= 1'b1;
    pix.red_in   <= r;
    pix.green_in <= g;
    pix.blue_in  <= b;
    do @(posedge clk_i); while (!pix.ready);
    sent++;
  endtask

  task automatic send_random(int count);
    repeat (count) send_pixel(pick_chan(), pick_chan(), pick_chan());
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(obhb_pkg::cfg_idx_e idx, logic [obhb_pkg::CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup(int w, int h, int b);
    drain();
    write_reg(obhb_pkg::REG_WIDTH, obhb_pkg::CFG_DATA_W'(w));
    write_reg(obhb_pkg::REG_HEIGHT, obhb_pkg::CFG_DATA_W'(h));
    write_reg(obhb_pkg::REG_BLUR, obhb_pkg::CFG_DATA_W'(b));
  endtask

  initial begin
    int w, h, b, n;
    pix.valid    <= 1'b0;
    pix.red_in   <= '0;
    pix.green_in <= '0;
    pix.blue_in  <= '0;
    cfg.valid    <= 1'b0;
    cfg.index    <= obhb_pkg::REG_WIDTH;
    cfg.data     <= '0;
    gaps_off = 1'b0;
    sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, then both width and blur lowered mid-row
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'h55, 8'hAA, 8'h55);
    setup(4, 2, 0);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd1, 8'd254, 8'd128);
    // zero width and height act as one
    setup(0, 0, 5);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd3, 8'd255, 8'd254);
    setup(6, 1, 2);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd254, 8'd1, 8'd127);
    setup(20, 3, 10);
    send_random(6);
    setup(20, 3, 3);
    send_random(3);

    // oversized width with the deepest window, then a full flush of the queue
    setup(8191, 8191, 63);
    send_random(70);
    setup(3, 4096, 63);
    send_random(4);

    // long result stall while pixels keep coming
    setup(5, 2, 0);
    gaps_off = 1'b1;
    hold_kicks++;
    send_random(40);
    gaps_off = 1'b0;

    while (sent < 150) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4);
      b = ($urandom_range(0, 9) == 0) ? $urandom_range(32, 63) : $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) begin
        b = b | ($urandom_range(0, 127) << obhb_pkg::BLUR_CFG_W);
      end
      n = $urandom_range(4, 30);
      gaps_off = ($urandom_range(0, 3) == 0);
      setup(w, h, b);
      send_random(n);
    end
    gaps_off = 1'b0;

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hdl/obhb_pkg.sv
hdl/obhb_if.sv
hdl/obhb_lane.sv
hdl/obhb_merge.sv
hdl/one_sided_horizontal_blur_unit.sv
dv/obhb_blur_checker.sv
dv/testbench.sv
